@@ design/lscn_pkg.sv @@
`timescale 1ns / 1ps

package lscn_pkg;

  // Field widths of the channels and the register.
  localparam int LABEL_W = 16;
  localparam int CHAN_W  = 8;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;
  localparam int TYPE_W  = 2;

  // Divisor used when no selected voxel raised the maximum.
  localparam logic [CHAN_W-1:0] ZERO_MAX_DIVISOR = 8'd5;
  // Largest quotient; larger results saturate here.
  localparam logic [CHAN_W-1:0] CHAN_SAT = 8'd255;
  // Quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = CHAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Request codes.
  typedef enum logic [TYPE_W-1:0] {
    REQ_MEASURE = 2'd0,
    REQ_RENDER  = 2'd1,
    REQ_LOAD    = 2'd2
  } req_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MATCH,
    ST_DECIDE,
    ST_DIV,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_write;
    logic scan_issue;
    logic decide;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic is_render;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ design/lscn_in_if.sv @@
`timescale 1ns / 1ps

interface lscn_in_if
  import lscn_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [LABEL_W-1:0] label;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic [INDEX_W-1:0] entry_index;
  logic               last;

  modport source (
    output valid, req_type, label, red, green, blue, entry_index, last,
    input  ready
  );

  modport sink (
    input  valid, req_type, label, red, green, blue, entry_index, last,
    output ready
  );
endinterface

@@ design/lscn_out_if.sv @@
`timescale 1ns / 1ps

interface lscn_out_if
  import lscn_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              selected;

  modport source (
    output valid, out_red, out_green, out_blue, selected,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, selected,
    output ready
  );
endinterface

@@ design/lscn_ctrl.sv @@
`timescale 1ns / 1ps

module lscn_ctrl
  import lscn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [TYPE_W-1:0] in_req_type,
  input  status_t           st,
  output logic              in_ready,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   is_voxel;

  assign accept   = in_valid && in_ready;
  assign is_voxel = (in_req_type == REQ_MEASURE) || (in_req_type == REQ_RENDER);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_voxel) begin
          state_next = st.cnt_zero ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.scan_last) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = st.is_render ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (st.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs. The input is held off while reset is high.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready       = !rst;
        cmd.capture    = in_valid && !rst && is_voxel;
        cmd.load_write = in_valid && !rst && (in_req_type == REQ_LOAD);
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
      end
      ST_MATCH: begin
        cmd = '0;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/lscn_datapath.sv @@
`timescale 1ns / 1ps

module lscn_datapath
  import lscn_pkg::*;
#(
  parameter int MAX_FRAGMENTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  cmd_t               cmd,
  output status_t            st,
  lscn_in_if.sink            req,
  lscn_out_if.source         rsp
);

  localparam int AW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CW = 9;
  localparam logic [CW-1:0] MAX_W = CW'(MAX_FRAGMENTS);

  // Fragment label table.
  logic [LABEL_W-1:0] mem [MAX_FRAGMENTS];
  logic [LABEL_W-1:0] rdata;

  logic [COUNT_W-1:0] fragment_count;
  logic [CHAN_W-1:0]  max_intensity;

  // Captured item.
  logic [LABEL_W-1:0] label;
  logic [CHAN_W-1:0]  chan [3];
  logic               render;
  logic               last;

  logic [AW-1:0]      scan_idx;
  logic               rd_pending;
  logic               hit;

  logic [CW-1:0]      cnt_eff;
  logic [CW-1:0]      wr_idx;
  logic               wr_ok;

  logic [CHAN_W-1:0]  divisor;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CHAN_W-1:0]  rem  [3];
  logic [CHAN_W-1:0]  quo  [3];
  logic               sat  [3];

  logic [2*CHAN_W-1:0] prod     [3];
  logic [CHAN_W-1:0]   rem_next [3];
  logic [CHAN_W-1:0]   quo_next [3];
  logic [CHAN_W-1:0]   res      [3];
  logic [CHAN_W-1:0]   meas_max;
  logic [CHAN_W-1:0]   div_sel;

  // Effective count and load slot range check.
  assign cnt_eff = (CW'(fragment_count) > MAX_W) ? MAX_W : CW'(fragment_count);
  assign wr_idx  = CW'(req.entry_index);
  assign wr_ok   = wr_idx < MAX_W;

  assign st.cnt_zero  = (cnt_eff == '0);
  assign st.scan_last = (CW'(scan_idx) == (cnt_eff - CW'(1)));
  assign st.is_render = render;
  assign st.div_last  = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign st.out_free  = !rsp.valid || rsp.ready;

  // Table write on load transfers, registered read during the scan.
  always_ff @(posedge clk) begin
    if (cmd.load_write && wr_ok) begin
      mem[wr_idx[AW-1:0]] <= req.label;
    end
    if (cmd.scan_issue) begin
      rdata <= mem[scan_idx];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_count <= '0;
    end else if (cfg_we) begin
      fragment_count <= cfg_wdata;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      label   <= req.label;
      chan[0] <= req.red;
      chan[1] <= req.green;
      chan[2] <= req.blue;
      render  <= (req.req_type == REQ_RENDER);
      last    <= req.last;
    end
  end

  // Scan counter and match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.scan_issue;
    end
    if (cmd.capture) begin
      scan_idx <= '0;
      hit      <= 1'b0;
    end else begin
      if (cmd.scan_issue) begin
        scan_idx <= scan_idx + AW'(1);
      end
      if (rd_pending && (rdata == label)) begin
        hit <= 1'b1;
      end
    end
  end

  // Largest channel of the measured voxel against the running maximum.
  always_comb begin
    meas_max = max_intensity;
    for (int i = 0; i < 3; i++) begin
      if (chan[i] > meas_max) begin
        meas_max = chan[i];
      end
    end
  end

  assign div_sel = (max_intensity == '0) ? ZERO_MAX_DIVISOR : max_intensity;

  // Running maximum: raised by selected measure voxels, cleared by the last render.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_intensity <= '0;
    end else if (cmd.decide && !render && hit) begin
      max_intensity <= meas_max;
    end else if (cmd.out_load && last) begin
      max_intensity <= '0;
    end
  end

  // Restoring division, one quotient bit per cycle on all three channels.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [CHAN_W:0] t;
      logic            ge;
      prod[i]     = {chan[i], {CHAN_W{1'b0}}} - {{(CHAN_W-1){1'b0}}, chan[i], 1'b0};
      t           = {rem[i], quo[i][CHAN_W-1]};
      ge          = (t >= {1'b0, divisor});
      rem_next[i] = ge ? CHAN_W'(t - {1'b0, divisor}) : t[CHAN_W-1:0];
      quo_next[i] = {quo[i][CHAN_W-2:0], ge};
      res[i]      = hit ? (sat[i] ? CHAN_SAT : quo[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      divisor <= div_sel;
      div_cnt <= '0;
      for (int i = 0; i < 3; i++) begin
        rem[i] <= prod[i][2*CHAN_W-1:CHAN_W];
        quo[i] <= prod[i][CHAN_W-1:0];
        sat[i] <= (prod[i] >= {div_sel, {CHAN_W{1'b0}}});
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      for (int i = 0; i < 3; i++) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (cmd.out_load) begin
      rsp.out_red   <= res[0];
      rsp.out_green <= res[1];
      rsp.out_blue  <= res[2];
      rsp.selected  <= hit;
    end
  end

endmodule

@@ design/label_set_composite_normalizer.sv @@
`timescale 1ns / 1ps
// Label-set composite normalizer.
// Input channel req carries one item per transfer: a load item writes one
// slot of the fragment label table, a measure voxel raises the running
// channel maximum when its label is in the table, and a render voxel gives
// one result on channel rsp with its channels scaled to floor(c*254/max),
// saturated at 255, or zeros when its label is not selected.
// cfg_we/cfg_wdata set fragment_count, the number of table slots searched;
// write it only while the block is idle.
// A load item is written to its slot on its transfer. A voxel item searches
// the table one slot per cycle through the table memory's read port, over
// N = min(fragment_count, MAX_FRAGMENTS) slots (none when N is 0); a render
// item then runs the bit-serial divider before its result is valid.
// Reset clears the maximum, fragment_count and the output valid flag; the
// table contents stay undefined until loaded.
// If the receiver stalls, the finished result waits in the output register
// while the next item is accepted and processed; a following render item
// then waits for that register to drain.
module label_set_composite_normalizer
  import lscn_pkg::*;
#(
  parameter int MAX_FRAGMENTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  lscn_in_if.sink            req,
  lscn_out_if.source         rsp
);

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign req.ready = in_ready;

  // Sequencer.
  lscn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .st          (st),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  // Table, maximum, divider and output register.
  lscn_datapath #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp       (rsp)
  );

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending result");

  // A loaded result is presented in the next cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> rsp.valid)
    else $error("loaded result not presented");

  // Unselected voxels give zero channels.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.selected) |->
      (rsp.out_red == '0 && rsp.out_green == '0 && rsp.out_blue == '0))
    else $error("unselected voxel with nonzero channels");

  // No item is taken while the divider runs.
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> !req.ready)
    else $error("input accepted during division");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lscn_pkg::*;

  localparam int TAB_DEPTH   = 16;
  // Cycles a voxel item may still be busy after its last result.
  localparam int SETTLE_CYC  = 2 * TAB_DEPTH + 12;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYC    = 300;
  localparam int ITEM_TARGET = 450;

  // The one request code the package leaves unnamed.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [TYPE_W-1:0]  kind;
    logic [LABEL_W-1:0] label;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [INDEX_W-1:0] slot;
    logic               last;
  } voxel_item_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              sel;
  } pixel_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  lscn_in_if  req_if ();
  lscn_out_if rsp_if ();

  label_set_composite_normalizer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Shadow state of the block, kept in step with accepted items.
  logic [LABEL_W-1:0] label_tab [TAB_DEPTH];
  logic [CHAN_W-1:0]  peak_level;
  logic [COUNT_W-1:0] frag_cnt;

  // Expected render pixels, oldest first.
  pixel_t pixel_q [$];

  int err_cnt   = 0;
  int item_cnt  = 0;
  int hold_len  = 0;
  bit idle_on   = 1'b1;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of table slots that are searched.
  function automatic int active_slots();
    return (frag_cnt > TAB_DEPTH) ? TAB_DEPTH : int'(frag_cnt);
  endfunction

  function automatic bit is_listed(input logic [LABEL_W-1:0] lbl);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < active_slots(); i++) begin
      if (label_tab[i] == lbl) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                   input logic [CHAN_W-1:0] div);
    int unsigned q;
    q = (int'(c) * 254) / int'(div);
    return (q > int'(CHAN_SAT)) ? CHAN_SAT : CHAN_W'(q);
  endfunction

  // Applies one accepted item to the shadow state and queues the pixel of a render item.
  function automatic void predict_voxel(input voxel_item_t it);
    pixel_t px;
    logic [CHAN_W-1:0] div;
    case (it.kind)
      REQ_LOAD: begin
        label_tab[it.slot] = it.label;
      end
      REQ_MEASURE: begin
        if (is_listed(it.label)) begin
          if (it.red > peak_level) peak_level = it.red;
          if (it.green > peak_level) peak_level = it.green;
          if (it.blue > peak_level) peak_level = it.blue;
        end
      end
      REQ_RENDER: begin
        div = (peak_level == '0) ? ZERO_MAX_DIVISOR : peak_level;
        if (is_listed(it.label)) begin
          px.red   = scale_chan(it.red, div);
          px.green = scale_chan(it.green, div);
          px.blue  = scale_chan(it.blue, div);
          px.sel   = 1'b1;
        end else begin
          px.red   = '0;
          px.green = '0;
          px.blue  = '0;
          px.sel   = 1'b0;
        end
        pixel_q.push_back(px);
        if (it.last) peak_level = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic voxel_item_t mk(input logic [TYPE_W-1:0] kind,
                                     input logic [LABEL_W-1:0] label,
                                     input logic [CHAN_W-1:0] r,
                                     input logic [CHAN_W-1:0] g,
                                     input logic [CHAN_W-1:0] b,
                                     input logic [INDEX_W-1:0] slot,
                                     input logic last);
    voxel_item_t it;
    it.kind  = kind;
    it.label = label;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.slot  = slot;
    it.last  = last;
    return it;
  endfunction

  // Offers one item, with an optional gap first, and waits for its transfer.
  // Valid stays high afterwards so back-to-back items follow without a gap.
  task automatic send_item(input voxel_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= it.kind;
    req_if.label       <= it.label;
    req_if.red         <= it.red;
    req_if.green       <= it.green;
    req_if.blue        <= it.blue;
    req_if.entry_index <= it.slot;
    req_if.last        <= it.last;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predict_voxel(it);
    item_cnt++;
  endtask

  // Stops offering, waits for every pixel and lets trailing work finish.
  task automatic wait_block_idle();
    req_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_fragment_count(input logic [COUNT_W-1:0] v);
    wait_block_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frag_cnt = v;
  endtask

  // Mostly labels from the searched slots, sometimes any label.
  function automatic logic [LABEL_W-1:0] pick_label();
    if (active_slots() > 0 && $urandom_range(0, 3) != 0)
      return label_tab[$urandom_range(0, active_slots() - 1)];
    return LABEL_W'($urandom);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan();
    case ($urandom_range(0, 3))
      0: return CHAN_W'($urandom_range(0, 7));
      1: return CHAN_W'($urandom_range(248, 255));
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // Fill every slot so no search ever reads an unwritten entry.
  task automatic test_table_load();
    for (int i = 0; i < TAB_DEPTH; i++) begin
      logic [LABEL_W-1:0] lbl;
      lbl = (i == 0) ? 16'h0000 : (i == TAB_DEPTH - 1) ? 16'hFFFF : LABEL_W'($urandom);
      send_item(mk(REQ_LOAD, lbl, 8'hFF, 8'h00, 8'hA5, INDEX_W'(i), i[0]));
    end
    // With no slots searched even a stored label is not selected.
    send_item(mk(REQ_RENDER, label_tab[0], 8'd200, 8'd100, 8'd50, '0, 1'b0));
  endtask

  // Zero maximum, saturation, the last flag and ignored request codes.
  task automatic test_scaling();
    set_fragment_count(COUNT_W'(TAB_DEPTH));
    send_item(mk(REQ_RENDER, label_tab[3], 8'd255, 8'd0, 8'd5, 4'hF, 1'b0));
    send_item(mk(REQ_MEASURE, ~label_tab[3] ^ 16'h1, 8'd255, 8'd255, 8'd255, '0, 1'b0));
    send_item(mk(REQ_MEASURE, label_tab[3], 8'd0, 8'd200, 8'd17, '0, 1'b1));
    send_item(mk(REQ_UNUSED, label_tab[3], 8'd255, 8'd255, 8'd255, 4'hF, 1'b1));
    send_item(mk(REQ_RENDER, label_tab[3], 8'd200, 8'd255, 8'd1, '0, 1'b1));
    send_item(mk(REQ_RENDER, label_tab[5], 8'd1, 8'd4, 8'd0, '0, 1'b0));
    send_item(mk(REQ_MEASURE, label_tab[15], 8'd255, 8'd3, 8'd9, '0, 1'b0));
    send_item(mk(REQ_RENDER, label_tab[15], 8'd255, 8'd254, 8'd0, '0, 1'b1));
    send_item(mk(REQ_MEASURE, label_tab[0], 8'd1, 8'd0, 8'd0, '0, 1'b0));
    send_item(mk(REQ_RENDER, label_tab[0], 8'd1, 8'd2, 8'd255, '0, 1'b0));
    send_item(mk(REQ_RENDER, 16'h1234 ^ label_tab[7], 8'd9, 8'd9, 8'd9, '0, 1'b1));
  endtask

  // No slots, a count beyond the table, and a single slot.
  task automatic test_count_extremes();
    set_fragment_count('0);
    send_item(mk(REQ_MEASURE, label_tab[0], 8'd255, 8'd255, 8'd255, '0, 1'b0));
    send_item(mk(REQ_RENDER, label_tab[0], 8'd255, 8'd255, 8'd255, '0, 1'b1));
    set_fragment_count('1);
    send_item(mk(REQ_MEASURE, label_tab[15], 8'd100, 8'd0, 8'd0, '0, 1'b0));
    send_item(mk(REQ_RENDER, label_tab[15], 8'd50, 8'd100, 8'd150, '0, 1'b1));
    set_fragment_count(COUNT_W'(1));
    send_item(mk(REQ_MEASURE, label_tab[1], 8'd255, 8'd255, 8'd255, '0, 1'b0));
    send_item(mk(REQ_RENDER, label_tab[0], 8'd3, 8'd0, 8'd7, '0, 1'b1));
  endtask

  // The receiver stalls long while render items keep coming.
  task automatic test_output_backpressure();
    set_fragment_count(COUNT_W'(TAB_DEPTH));
    hold_len = HOLD_CYC;
    for (int i = 0; i < 10; i++)
      send_item(mk(REQ_RENDER, pick_label(), pick_chan(), pick_chan(), pick_chan(),
                   INDEX_W'($urandom), i == 9));
  endtask

  // One measure pass and one render pass, plus some loads and noise.
  task automatic run_frame();
    int nvox;
    nvox = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    repeat ($urandom_range(0, 2))
      send_item(mk(REQ_LOAD, LABEL_W'($urandom), pick_chan(), pick_chan(), pick_chan(),
                   INDEX_W'($urandom), 1'($urandom)));
    repeat (nvox)
      send_item(mk(REQ_MEASURE, pick_label(), pick_chan(), pick_chan(), pick_chan(),
                   INDEX_W'($urandom), 1'($urandom)));
    for (int i = 0; i < nvox; i++)
      send_item(mk(REQ_RENDER, pick_label(), pick_chan(), pick_chan(), pick_chan(),
                   INDEX_W'($urandom), (i == nvox - 1) || ($urandom_range(0, 15) == 0)));
    repeat ($urandom_range(0, 2))
      send_item(mk(TYPE_W'($urandom_range(0, 3)), pick_label(), pick_chan(), pick_chan(),
                   pick_chan(), INDEX_W'($urandom), 1'($urandom)));
  endtask

  // The remaining item budget is split evenly over the phases.
  task automatic test_random_frames();
    logic [COUNT_W-1:0] counts [8];
    int goal;
    int step;
    counts = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd15, 5'd16};
    goal = item_cnt;
    step = (ITEM_TARGET - item_cnt) / 8;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_on = 1'b0;
      set_fragment_count((ph == 0 || ph == 7) ? counts[ph] : counts[$urandom_range(0, 7)]);
      goal += step;
      while (item_cnt < goal) run_frame();
    end
  endtask

  // Stimulus.
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_MEASURE;
    req_if.label       <= '0;
    req_if.red         <= '0;
    req_if.green       <= '0;
    req_if.blue        <= '0;
    req_if.entry_index <= '0;
    req_if.last        <= 1'b0;
    peak_level = '0;
    frag_cnt   = '0;
    foreach (label_tab[i]) label_tab[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_load();
    test_scaling();
    test_count_extremes();
    test_output_backpressure();
    test_random_frames();

    wait_block_idle();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stalls, the long hold-off, and the pixel check.
  initial begin : rsp_side
    pixel_t want;
    int gap_left;
    gap_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pixel_q.size() == 0) begin
          $error("result transfer with no render item pending");
          err_cnt++;
        end else begin
          want = pixel_q.pop_front();
          if (rsp_if.out_red !== want.red) begin
            $error("out_red: expected %0d, actual %0d", want.red, rsp_if.out_red);
            err_cnt++;
          end
          if (rsp_if.out_green !== want.green) begin
            $error("out_green: expected %0d, actual %0d", want.green, rsp_if.out_green);
            err_cnt++;
          end
          if (rsp_if.out_blue !== want.blue) begin
            $error("out_blue: expected %0d, actual %0d", want.blue, rsp_if.out_blue);
            err_cnt++;
          end
          if (rsp_if.selected !== want.sel) begin
            $error("selected: expected %0d, actual %0d", want.sel, rsp_if.selected);
            err_cnt++;
          end
        end
      end
      if (hold_len > 0) begin
        gap_left = hold_len;
        hold_len = 0;
      end
      if (gap_left > 0) begin
        rsp_if.ready <= 1'b0;
        gap_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        gap_left = $urandom_range(1, 12) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer means the block hung.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
